// File: hdl/egbs_pkg.sv
// ----------------------------------------------------------------------------
// egbs_pkg
// Shared types and codes for the energy gated bundle scheduler.
// ----------------------------------------------------------------------------
package egbs_pkg;

  // operation codes
  localparam logic [1:0] MODE_ENQUEUE = 2'd0;
  localparam logic [1:0] MODE_RELEASE = 2'd1;
  localparam logic [1:0] MODE_REMOVE  = 2'd2;
  localparam logic [1:0] MODE_PURGE   = 2'd3;

  // result status codes
  localparam logic [2:0] ST_ENQUEUED = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_RELEASED = 3'd2;
  localparam logic [2:0] ST_NONE     = 3'd3;
  localparam logic [2:0] ST_REMOVED  = 3'd4;
  localparam logic [2:0] ST_NOTFOUND = 3'd5;
  localparam logic [2:0] ST_PURGED   = 3'd6;

  // configuration register indexes
  localparam logic [1:0] CFG_SOC    = 2'd0;
  localparam logic [1:0] CFG_GUARD  = 2'd1;
  localparam logic [1:0] CFG_ECLIPSE = 2'd2;
  localparam logic [1:0] CFG_GATING = 2'd3;

  localparam logic [1:0] PRI_EXPEDITED = 2'd2;

  // most release beats per query
  localparam int unsigned MAX_OUT = 32;

  // one stored bundle
  typedef struct packed {
    logic [31:0] id;
    logic [1:0]  pri;
    logic [40:0] expiry;
    logic [31:0] seq;
  } entry_t;

endpackage

// File: hdl/egbs_ram.sv
// ----------------------------------------------------------------------------
// egbs_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module egbs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: hdl/energy_gated_bundle_scheduler_core.sv
// ----------------------------------------------------------------------------
// energy_gated_bundle_scheduler_core
// Bounded bundle store with energy gated priority / earliest deadline release.
// ----------------------------------------------------------------------------
// Usage: raise start_i with mode_i and the operands while busy_o is low; the
// command is taken at that edge. Results appear as beats flagged by
// out_valid_o, the final beat of a command carries last_o.
// Enqueue finishes at the accept edge: its beat shows in the next cycle and
// busy_o stays low, so enqueues may follow back to back.
// Remove and purge walk the whole entry RAM once, then show the single beat
// and busy_o drops. Release runs one select-best walk over the RAM per
// emitted entry; a beat is shown one walk late since last_o is only known
// when the following walk finds nothing or the MAX_OUT cap is reached.
// The walk pace is set by the single read port of the entry RAM.
// Reset empties the store (valid bits cleared at once, no clearing pass) and
// loads the register defaults. Configuration writes land at once via cfg_we_i
// and are to be issued only while busy_o is low; the block does not enforce
// it. The receiver cannot stall: every beat is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module energy_gated_bundle_scheduler_core import egbs_pkg::*; #(
  parameter int unsigned STORE_DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_wdata_i,
  // command
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  mode_i,
  input  logic [31:0] bundle_id_i,
  input  logic [1:0]  priority_level_i,
  input  logic [39:0] creation_ms_i,
  input  logic [39:0] lifetime_ms_i,
  input  logic [40:0] now_ms_i,
  input  logic        sunlit_i,
  input  logic [9:0]  soc_permille_i,
  // results
  output logic        out_valid_o,
  output logic [2:0]  status_o,
  output logic [31:0] out_id_o,
  output logic [1:0]  out_priority_o,
  output logic [40:0] out_expiry_ms_o,
  output logic [5:0]  purged_count_o,
  output logic [5:0]  occupancy_o,
  output logic        last_o
);

  localparam int unsigned AW = $clog2(STORE_DEPTH);
  localparam int unsigned CW = $clog2(STORE_DEPTH + 1);
  localparam int unsigned EW = $bits(entry_t);
  localparam logic [AW-1:0] LAST_IDX = AW'(STORE_DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_CNT = CW'(STORE_DEPTH);
  localparam logic [5:0] MAX_BEATS = 6'(MAX_OUT);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;

  // configuration registers
  logic [9:0]  soc_thr_q;
  logic [31:0] guard_q;
  logic        eclipse_q;
  logic        gating_q;

  // control state
  logic [1:0]             state_q;
  logic [STORE_DEPTH-1:0] valid_q;
  logic [STORE_DEPTH-1:0] done_q;
  logic [CW-1:0]          count_q;
  logic [31:0]            next_seq_q;
  logic [AW-1:0]          scan_q;
  logic                   iss_q;
  logic                   dv_q;
  logic [AW-1:0]          didx_q;
  logic [5:0]             nrel_q;
  logic [CW-1:0]          purged_q;

  // latched command
  logic [1:0]  op_q;
  logic [31:0] key_q;
  logic [40:0] now_q;
  logic [41:0] limit_q;
  logic        sun_q;
  logic [9:0]  soc_q;

  // running best of a walk
  logic          best_have_q;
  entry_t        best_q;
  logic [AW-1:0] best_idx_q;

  // pending release beat
  logic   pend_have_q;
  entry_t pend_q;

  // result registers
  logic        out_valid_q;
  logic [2:0]  res_status_q;
  logic [31:0] res_id_q;
  logic [1:0]  res_pri_q;
  logic [40:0] res_exp_q;
  logic [CW-1:0] res_purged_q;
  logic [CW-1:0] res_occ_q;
  logic        res_last_q;

  // entry RAM
  logic    ram_we;
  logic [AW-1:0] free_idx;
  entry_t  wr_entry;
  entry_t  rd_entry;
  logic [EW-1:0] rd_raw;

  egbs_ram #(
    .WIDTH (EW),
    .DEPTH (STORE_DEPTH)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (free_idx),
    .wdata_i (wr_entry),
    .raddr_i (scan_q),
    .rdata_o (rd_raw)
  );

  assign rd_entry = entry_t'(rd_raw);

  // first free slot
  always_comb begin
    free_idx = '0;
    for (int i = STORE_DEPTH - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_idx = AW'(i);
      end
    end
  end

  logic accept;
  logic full;
  assign accept = start_i && (state_q == S_IDLE);
  assign full   = (count_q >= DEPTH_CNT);
  assign ram_we = accept && (mode_i == MODE_ENQUEUE) && !full;

  // new entry
  always_comb begin
    wr_entry.id     = bundle_id_i;
    wr_entry.pri    = (priority_level_i > PRI_EXPEDITED) ? PRI_EXPEDITED : priority_level_i;
    wr_entry.expiry = {1'b0, creation_ms_i} + {1'b0, lifetime_ms_i};
    wr_entry.seq    = next_seq_q;
  end

  // evaluation of the entry coming out of the RAM
  logic   slot_ok;
  logic   is_safe;
  logic   rd_older;
  logic   rd_before;
  logic   purge_hit;
  logic   pick;
  logic   pass_end;
  logic   best_have_n;
  entry_t best_n;
  logic [AW-1:0] best_idx_n;
  logic [31:0]   seq_diff;

  assign slot_ok  = dv_q && valid_q[didx_q];
  assign seq_diff = rd_entry.seq - best_q.seq;
  assign rd_older = seq_diff[31];
  assign pass_end = dv_q && (didx_q == LAST_IDX);

  // energy rule
  always_comb begin
    if ({1'b0, rd_entry.expiry} <= limit_q || !gating_q) begin
      is_safe = 1'b1;
    end else if (rd_entry.pri == PRI_EXPEDITED) begin
      is_safe = eclipse_q || sun_q;
    end else begin
      is_safe = sun_q || (soc_q >= soc_thr_q);
    end
  end

  // release order
  always_comb begin
    if (rd_entry.pri != best_q.pri) begin
      rd_before = rd_entry.pri > best_q.pri;
    end else if (rd_entry.expiry != best_q.expiry) begin
      rd_before = rd_entry.expiry < best_q.expiry;
    end else begin
      rd_before = rd_older;
    end
  end

  assign purge_hit = slot_ok && (op_q == MODE_PURGE) && (rd_entry.expiry <= now_q);

  always_comb begin
    unique case (op_q)
      MODE_RELEASE: pick = slot_ok && !done_q[didx_q] && is_safe
                           && (!best_have_q || rd_before);
      MODE_REMOVE:  pick = slot_ok && (rd_entry.id == key_q)
                           && (!best_have_q || rd_older);
      default:      pick = 1'b0;
    endcase
  end

  always_comb begin
    best_have_n = best_have_q || pick;
    best_n      = pick ? rd_entry : best_q;
    best_idx_n  = pick ? didx_q : best_idx_q;
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      soc_thr_q <= 10'd400;
      guard_q   <= 32'd60000;
      eclipse_q <= 1'b1;
      gating_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SOC:     soc_thr_q <= cfg_wdata_i[9:0];
        CFG_GUARD:   guard_q   <= cfg_wdata_i;
        CFG_ECLIPSE: eclipse_q <= cfg_wdata_i[0];
        CFG_GATING:  gating_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      valid_q      <= '0;
      done_q       <= '0;
      count_q      <= '0;
      next_seq_q   <= '0;
      scan_q       <= '0;
      iss_q        <= 1'b0;
      dv_q         <= 1'b0;
      didx_q       <= '0;
      nrel_q       <= '0;
      purged_q     <= '0;
      op_q         <= MODE_ENQUEUE;
      key_q        <= '0;
      now_q        <= '0;
      limit_q      <= '0;
      sun_q        <= 1'b0;
      soc_q        <= '0;
      best_have_q  <= 1'b0;
      best_q       <= '0;
      best_idx_q   <= '0;
      pend_have_q  <= 1'b0;
      pend_q       <= '0;
      out_valid_q  <= 1'b0;
      res_status_q <= ST_ENQUEUED;
      res_id_q     <= '0;
      res_pri_q    <= '0;
      res_exp_q    <= '0;
      res_purged_q <= '0;
      res_occ_q    <= '0;
      res_last_q   <= 1'b0;
    end else begin
      out_valid_q <= 1'b0;

      // read issue and data stage
      dv_q   <= iss_q;
      didx_q <= scan_q;
      if (iss_q) begin
        if (scan_q == LAST_IDX) begin
          iss_q <= 1'b0;
        end else begin
          scan_q <= scan_q + 1'b1;
        end
      end

      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            op_q        <= mode_i;
            key_q       <= bundle_id_i;
            now_q       <= now_ms_i;
            limit_q     <= {1'b0, now_ms_i} + {10'd0, guard_q};
            sun_q       <= sunlit_i;
            soc_q       <= soc_permille_i;
            best_have_q <= 1'b0;
            pend_have_q <= 1'b0;
            nrel_q      <= '0;
            purged_q    <= '0;
            done_q      <= '0;
            if (mode_i == MODE_ENQUEUE) begin
              // insert without a walk
              out_valid_q  <= 1'b1;
              res_id_q     <= '0;
              res_pri_q    <= '0;
              res_exp_q    <= '0;
              res_purged_q <= '0;
              res_last_q   <= 1'b1;
              if (full) begin
                res_status_q <= ST_FULL;
                res_occ_q    <= count_q;
              end else begin
                valid_q[free_idx] <= 1'b1;
                next_seq_q   <= next_seq_q + 32'd1;
                count_q      <= count_q + 1'b1;
                res_status_q <= ST_ENQUEUED;
                res_occ_q    <= count_q + 1'b1;
              end
            end else begin
              state_q <= S_SCAN;
              scan_q  <= '0;
              iss_q   <= 1'b1;
            end
          end
        end

        S_SCAN: begin
          best_have_q <= best_have_n;
          best_q      <= best_n;
          best_idx_q  <= best_idx_n;
          if (purge_hit) begin
            valid_q[didx_q] <= 1'b0;
            count_q  <= count_q - 1'b1;
            purged_q <= purged_q + 1'b1;
          end
          if (pass_end) begin
            res_id_q     <= '0;
            res_pri_q    <= '0;
            res_exp_q    <= '0;
            res_purged_q <= '0;
            res_last_q   <= 1'b1;
            unique case (op_q)
              MODE_PURGE: begin
                out_valid_q  <= 1'b1;
                res_status_q <= ST_PURGED;
                res_purged_q <= purged_q + CW'(purge_hit);
                res_occ_q    <= count_q - CW'(purge_hit);
                state_q      <= S_IDLE;
              end
              MODE_REMOVE: begin
                out_valid_q <= 1'b1;
                state_q     <= S_IDLE;
                res_occ_q   <= count_q;
                if (best_have_n) begin
                  valid_q[best_idx_n] <= 1'b0;
                  count_q      <= count_q - 1'b1;
                  res_status_q <= ST_REMOVED;
                  res_occ_q    <= count_q - 1'b1;
                end else begin
                  res_status_q <= ST_NOTFOUND;
                end
              end
              default: begin
                // release: show the previous pick once this walk is done
                res_occ_q <= count_q;
                if (best_have_n) begin
                  done_q[best_idx_n] <= 1'b1;
                  pend_have_q <= 1'b1;
                  pend_q      <= best_n;
                  nrel_q      <= nrel_q + 6'd1;
                  best_have_q <= 1'b0;
                  if (pend_have_q) begin
                    out_valid_q  <= 1'b1;
                    res_status_q <= ST_RELEASED;
                    res_id_q     <= pend_q.id;
                    res_pri_q    <= pend_q.pri;
                    res_exp_q    <= pend_q.expiry;
                    res_last_q   <= 1'b0;
                  end
                  if (nrel_q + 6'd1 == MAX_BEATS) begin
                    state_q <= S_FLUSH;
                  end else begin
                    scan_q <= '0;
                    iss_q  <= 1'b1;
                  end
                end else begin
                  out_valid_q <= 1'b1;
                  state_q     <= S_IDLE;
                  if (pend_have_q) begin
                    res_status_q <= ST_RELEASED;
                    res_id_q     <= pend_q.id;
                    res_pri_q    <= pend_q.pri;
                    res_exp_q    <= pend_q.expiry;
                  end else begin
                    res_status_q <= ST_NONE;
                  end
                end
              end
            endcase
          end
        end

        S_FLUSH: begin
          // release cap reached: last pending beat
          out_valid_q  <= 1'b1;
          res_status_q <= ST_RELEASED;
          res_id_q     <= pend_q.id;
          res_pri_q    <= pend_q.pri;
          res_exp_q    <= pend_q.expiry;
          res_purged_q <= '0;
          res_occ_q    <= count_q;
          res_last_q   <= 1'b1;
          state_q      <= S_IDLE;
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  // outputs
  assign busy_o          = (state_q != S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign status_o        = res_status_q;
  assign out_id_o        = res_id_q;
  assign out_priority_o  = res_pri_q;
  assign out_expiry_ms_o = res_exp_q;
  assign purged_count_o  = 6'(res_purged_q);
  assign occupancy_o     = 6'(res_occ_q);
  assign last_o          = res_last_q;

  // checks
  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(count_q))
    else $error("entry count differs from valid bits");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DEPTH_CNT)
    else $error("entry count above store depth");

  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (res_status_q != ST_RELEASED) |-> res_last_q)
    else $error("single beat result without last");

  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_last_q |-> !busy_o)
    else $error("busy after final beat");

endmodule

// File: verif/energy_gated_bundle_scheduler_core_test.sv
// ----------------------------------------------------------------------------
// energy_gated_bundle_scheduler_core_test
// Self-checking bench: commands go in through a bursty driver, every beat
// is compared against an in-bench model of the bundle store and its
// energy-gated release order, across several register settings.
// ----------------------------------------------------------------------------
module energy_gated_bundle_scheduler_core_test;
  import egbs_pkg::*;

  localparam int DEPTH = 32;

  typedef struct {
    logic [1:0]  mode;
    logic [31:0] id;
    logic [1:0]  pri;
    logic [39:0] cre;
    logic [39:0] life;
    logic [40:0] now;
    logic        sun;
    logic [9:0]  soc;
  } cmd_t;

  typedef struct {
    logic [2:0]  status;
    logic [31:0] id;
    logic [1:0]  pri;
    logic [40:0] expiry;
    logic [5:0]  purged;
    logic [5:0]  occ;
    logic        last;
  } beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [31:0] cfg_wdata_i = '0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [1:0]  mode_i = '0;
  logic [31:0] bundle_id_i = '0;
  logic [1:0]  priority_level_i = '0;
  logic [39:0] creation_ms_i = '0;
  logic [39:0] lifetime_ms_i = '0;
  logic [40:0] now_ms_i = '0;
  logic        sunlit_i = 1'b0;
  logic [9:0]  soc_permille_i = '0;
  logic        out_valid_o;
  logic [2:0]  status_o;
  logic [31:0] out_id_o;
  logic [1:0]  out_priority_o;
  logic [40:0] out_expiry_ms_o;
  logic [5:0]  purged_count_o;
  logic [5:0]  occupancy_o;
  logic        last_o;

  energy_gated_bundle_scheduler_core #(.STORE_DEPTH(DEPTH)) DUT (.*);

  always #4 clk_i = ~clk_i;

  // store model
  logic [9:0]  soc_floor = 10'd400;
  logic [31:0] guard_ms = 32'd60000;
  logic        eclipse_ok = 1'b1;
  logic        gating_on = 1'b0;
  logic        held[DEPTH];
  logic [31:0] held_id[DEPTH];
  logic [1:0]  held_pri[DEPTH];
  logic [40:0] held_exp[DEPTH];
  logic [31:0] held_seq[DEPTH];
  logic [31:0] seq_next = '0;
  int          held_count = 0;

  cmd_t  pending[$];
  beat_t due_beats[$];
  cmd_t  cur;
  int    err_count = 0;
  int    burst_left = 0;
  int    gap_left = 0;

  // base time and id pool for random commands
  logic [39:0] t_base;
  logic [31:0] id_pool[8];

  function automatic logic is_older(logic [31:0] a, logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d[31];
  endfunction

  function automatic logic goes_first(int a, int b);
    if (held_pri[a] != held_pri[b]) return held_pri[a] > held_pri[b];
    if (held_exp[a] != held_exp[b]) return held_exp[a] < held_exp[b];
    return is_older(held_seq[a], held_seq[b]);
  endfunction

  function automatic logic power_ok(int s, logic [40:0] now, logic sun, logic [9:0] soc);
    logic [42:0] horizon;
    horizon = {2'b0, now} + {11'b0, guard_ms};
    if ({2'b0, held_exp[s]} <= horizon) return 1'b1;
    if (!gating_on) return 1'b1;
    if (held_pri[s] == PRI_EXPEDITED) return eclipse_ok | sun;
    if (sun) return 1'b1;
    return soc >= soc_floor;
  endfunction

  function automatic beat_t plain_beat(logic [2:0] st, logic [5:0] purged);
    beat_t b;
    b.status = st; b.id = '0; b.pri = '0; b.expiry = '0;
    b.purged = purged; b.occ = 6'(held_count); b.last = 1'b1;
    return b;
  endfunction

  // append helpers for the two queues
  function automatic void add_beat(beat_t b);
    due_beats.insert(due_beats.size(), b);
  endfunction

  function automatic void add_cmd(cmd_t c);
    pending.insert(pending.size(), c);
  endfunction

  // apply one accepted command to the model and queue its beats
  task automatic apply_command(cmd_t c);
    int    s, hit, best, n, dropped;
    logic  taken[DEPTH];
    beat_t b;
    case (c.mode)
      MODE_ENQUEUE: begin
        hit = -1;
        for (s = 0; s < DEPTH; s++) if (!held[s] && hit < 0) hit = s;
        if (hit < 0) add_beat(plain_beat(ST_FULL, '0));
        else begin
          held[hit] = 1'b1;
          held_id[hit] = c.id;
          held_pri[hit] = (c.pri > PRI_EXPEDITED) ? PRI_EXPEDITED : c.pri;
          held_exp[hit] = {1'b0, c.cre} + {1'b0, c.life};
          held_seq[hit] = seq_next;
          seq_next++;
          held_count++;
          add_beat(plain_beat(ST_ENQUEUED, '0));
        end
      end
      MODE_RELEASE: begin
        for (s = 0; s < DEPTH; s++) taken[s] = 1'b0;
        n = 0;
        do begin
          best = -1;
          for (s = 0; s < DEPTH; s++)
            if (held[s] && !taken[s] && power_ok(s, c.now, c.sun, c.soc))
              if (best < 0 || goes_first(s, best)) best = s;
          if (best >= 0) begin
            taken[best] = 1'b1;
            b = plain_beat(ST_RELEASED, '0);
            b.id = held_id[best]; b.pri = held_pri[best]; b.expiry = held_exp[best];
            b.last = 1'b0;
            add_beat(b);
            n++;
          end
        end while (best >= 0 && n < MAX_OUT);
        if (n == 0) add_beat(plain_beat(ST_NONE, '0));
        else due_beats[$].last = 1'b1;
      end
      MODE_REMOVE: begin
        hit = -1;
        for (s = 0; s < DEPTH; s++)
          if (held[s] && held_id[s] == c.id &&
              (hit < 0 || is_older(held_seq[s], held_seq[hit]))) hit = s;
        if (hit < 0) add_beat(plain_beat(ST_NOTFOUND, '0));
        else begin
          held[hit] = 1'b0;
          held_count--;
          add_beat(plain_beat(ST_REMOVED, '0));
        end
      end
      default: begin
        dropped = 0;
        for (s = 0; s < DEPTH; s++)
          if (held[s] && held_exp[s] <= c.now) begin
            held[s] = 1'b0;
            dropped++;
            held_count--;
          end
        add_beat(plain_beat(ST_PURGED, 6'(dropped)));
      end
    endcase
  endtask

  // command driver: bursts with random gaps
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) apply_command(cur);
      if (!start_i || !busy_o) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start_i <= 1'b0;
        end else if (pending.size() > 0) begin
          cur = pending.pop_front();
          mode_i <= cur.mode;
          bundle_id_i <= cur.id;
          priority_level_i <= cur.pri;
          creation_ms_i <= cur.cre;
          lifetime_ms_i <= cur.life;
          now_ms_i <= cur.now;
          sunlit_i <= cur.sun;
          soc_permille_i <= cur.soc;
          start_i <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else burst_left <= burst_left - 1;
        end else start_i <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    beat_t e;
    if (rst_ni && out_valid_o) begin
      if (due_beats.size() == 0) begin
        $error("unexpected beat, status %0d", status_o);
        err_count++;
      end else begin
        e = due_beats.pop_front();
        if (status_o !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, status_o); err_count++;
        end
        if (out_id_o !== e.id) begin
          $error("out_id: expected %h, got %h", e.id, out_id_o); err_count++;
        end
        if (out_priority_o !== e.pri) begin
          $error("out_priority: expected %0d, got %0d", e.pri, out_priority_o); err_count++;
        end
        if (out_expiry_ms_o !== e.expiry) begin
          $error("out_expiry_ms: expected %h, got %h", e.expiry, out_expiry_ms_o);
          err_count++;
        end
        if (purged_count_o !== e.purged) begin
          $error("purged_count: expected %0d, got %0d", e.purged, purged_count_o);
          err_count++;
        end
        if (occupancy_o !== e.occ) begin
          $error("occupancy: expected %0d, got %0d", e.occ, occupancy_o); err_count++;
        end
        if (last_o !== e.last) begin
          $error("last: expected %0d, got %0d", e.last, last_o); err_count++;
        end
      end
    end
  end

  function automatic cmd_t mk(logic [1:0] m, logic [31:0] id, logic [1:0] p,
                              logic [39:0] cr, logic [39:0] lf, logic [40:0] nw,
                              logic sn, logic [9:0] sc);
    cmd_t c;
    c.mode = m; c.id = id; c.pri = p; c.cre = cr; c.life = lf;
    c.now = nw; c.sun = sn; c.soc = sc;
    return c;
  endfunction

  // random command around the current base time
  function automatic cmd_t rand_cmd(logic [1:0] m);
    cmd_t c;
    int   r;
    c.mode = m;
    c.id = ($urandom_range(0, 4) == 0) ? $urandom() : id_pool[$urandom_range(0, 7)];
    c.pri = 2'($urandom_range(0, 3));
    c.cre = t_base - 40'($urandom_range(0, 100000));
    c.life = 40'($urandom_range(0, 300000));
    c.now = {1'b0, t_base} + 41'($urandom_range(0, 200000));
    c.sun = 1'($urandom());
    r = $urandom_range(0, 3);
    c.soc = (r == 0) ? soc_floor : 10'($urandom_range(0, 1000));
    if ($urandom_range(0, 30) == 0) begin
      c.cre = {$urandom(), 8'($urandom())};
      c.life = {$urandom(), 8'($urandom())};
      c.now = {$urandom(), 9'($urandom())};
    end
    return c;
  endfunction

  task automatic wait_drained();
    do @(posedge clk_i);
    while (pending.size() != 0 || start_i || busy_o || due_beats.size() != 0);
    repeat (DEPTH * 3) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_SOC:     soc_floor = val[9:0];
      CFG_GUARD:   guard_ms = val;
      CFG_ECLIPSE: eclipse_ok = val[0];
      default:     gating_on = val[0];
    endcase
  endtask

  task automatic random_phase(int n_items);
    int k, j, r;
    for (k = 0; k < 8; k++) id_pool[k] = $urandom();
    k = 0;
    while (k < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        // fill to full, then drain with a wide release
        for (j = 0; j < DEPTH + 2; j++) add_cmd(rand_cmd(MODE_ENQUEUE));
        add_cmd(rand_cmd(MODE_RELEASE));
        k += DEPTH + 3;
      end else begin
        if (r < 45) add_cmd(rand_cmd(MODE_ENQUEUE));
        else if (r < 65) add_cmd(rand_cmd(MODE_RELEASE));
        else if (r < 85) add_cmd(rand_cmd(MODE_REMOVE));
        else add_cmd(rand_cmd(MODE_PURGE));
        k++;
      end
      if ($urandom_range(0, 15) == 0) t_base += 40'($urandom_range(0, 150000));
    end
  endtask

  initial begin
    int p;
    for (p = 0; p < DEPTH; p++) held[p] = 1'b0;
    t_base = 40'h00_8000_0000;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty cases, field extremes, saturated priority
    add_cmd(mk(MODE_RELEASE, '0, '0, '0, '0, '0, 1'b0, '0));
    add_cmd(mk(MODE_REMOVE, 32'hFFFF_FFFF, '0, '0, '0, '0, 1'b0, '0));
    add_cmd(mk(MODE_PURGE, '0, '0, '0, '0, {41{1'b1}}, 1'b0, '0));
    add_cmd(mk(MODE_ENQUEUE, 32'h0, 2'd0, '0, '0, '0, 1'b0, '0));
    add_cmd(mk(MODE_ENQUEUE, 32'hFFFF_FFFF, 2'd3, {40{1'b1}}, {40{1'b1}},
               {41{1'b1}}, 1'b1, 10'd1000));
    add_cmd(mk(MODE_ENQUEUE, 32'h5A5A_0001, 2'd1, 40'd1000, 40'd500, '0, 1'b0, '0));
    add_cmd(mk(MODE_ENQUEUE, 32'h5A5A_0001, 2'd1, 40'd1000, 40'd500, '0, 1'b0, '0));
    add_cmd(mk(MODE_ENQUEUE, 32'h1234_5678, 2'd2, 40'd10, 40'd20, '0, 1'b0, '0));
    add_cmd(mk(MODE_RELEASE, '0, '0, '0, '0, 41'd0, 1'b0, 10'd0));
    add_cmd(mk(MODE_REMOVE, 32'h5A5A_0001, '0, '0, '0, '0, 1'b0, '0));
    add_cmd(mk(MODE_RELEASE, '0, '0, '0, '0, {41{1'b1}}, 1'b1, 10'd1000));
    add_cmd(mk(MODE_PURGE, '0, '0, '0, '0, 41'd1500, 1'b0, '0));
    add_cmd(mk(MODE_PURGE, '0, '0, '0, '0, 41'd1499, 1'b0, '0));
    add_cmd(mk(MODE_RELEASE, '0, '0, '0, '0, 41'd0, 1'b0, 10'd1023));
    add_cmd(mk(MODE_PURGE, '0, '0, '0, '0, {41{1'b1}}, 1'b0, '0));
    random_phase(60);
    wait_drained();

    // gating on, strictest thresholds
    write_reg(CFG_GATING, 32'd1);
    write_reg(CFG_SOC, 32'd1000);
    write_reg(CFG_GUARD, 32'd0);
    write_reg(CFG_ECLIPSE, 32'd0);
    random_phase(90);
    wait_drained();

    // gating on, loosest thresholds
    write_reg(CFG_SOC, 32'd0);
    write_reg(CFG_GUARD, 32'hFFFF_FFFF);
    write_reg(CFG_ECLIPSE, 32'd1);
    random_phase(90);
    wait_drained();

    // gating on, middling thresholds
    write_reg(CFG_SOC, 32'd400);
    write_reg(CFG_GUARD, 32'd60000);
    write_reg(CFG_ECLIPSE, 32'd0);
    random_phase(90);
    wait_drained();

    // random thresholds, gating off then on
    write_reg(CFG_GATING, 32'd0);
    write_reg(CFG_SOC, 32'($urandom_range(0, 1000)));
    write_reg(CFG_GUARD, 32'($urandom_range(0, 150000)));
    random_phase(45);
    wait_drained();
    write_reg(CFG_GATING, 32'd1);
    write_reg(CFG_ECLIPSE, 32'($urandom_range(0, 1)));
    random_phase(45);
    wait_drained();

    if (err_count == 0) $display("energy_gated_bundle_scheduler_core_test: clean");
    else $display("energy_gated_bundle_scheduler_core_test: errors");
    $finish;
  end

  // watchdog
  initial begin
    #40000000;
    $display("energy_gated_bundle_scheduler_core_test: errors");
    $finish;
  end

endmodule
